// ----- src/tt_pkg.sv -----
package tt_pkg;

    localparam int INDEX_WIDTH = 16;
    localparam int IDX_W       = 16;
    localparam int COORD_W     = 32;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int WIDE_W      = PROD_W + 1;
    localparam int MAG_W       = PROD_W;
    localparam int NORM_BITS   = 24;
    localparam int SUM_W       = 2 * NORM_BITS + 2;
    localparam int RAD_W       = SUM_W + 12;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int QUO_W       = 32;
    localparam int OUT_W       = 32;
    localparam logic [QUO_W-1:0] ONE_Q30 = QUO_W'(1) << 30;

    typedef struct packed {
        logic [IDX_W-1:0]          vertex_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
    } t_vertex;

    typedef struct packed {
        logic [IDX_W-1:0]        index_first;
        logic [IDX_W-1:0]        index_second;
        logic [IDX_W-1:0]        index_third;
        logic signed [OUT_W-1:0] tangent_x;
        logic signed [OUT_W-1:0] tangent_y;
        logic signed [OUT_W-1:0] tangent_z;
        logic                    degenerate;
    } t_tangent;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_PROD,
        ST_NORM,
        ST_SQUARE,
        ST_ROOT,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ----- src/tt_vertex_if.sv -----
interface tt_vertex_if;
    import tt_pkg::*;
    logic    valid;
    logic    ready;
    t_vertex data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- src/tt_tangent_if.sv -----
interface tt_tangent_if;
    import tt_pkg::*;
    logic     valid;
    logic     ready;
    t_tangent data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- src/triangle_tangent_generator.sv -----
// Per-triangle unit tangent from vertex positions and texture coordinates.
// The first two vertices are taken one per cycle; the third starts the computation:
// 8 products and 3 squares on one shared 33x33 multiplier, a normalize shift, a square
// root and three divides (a degenerate triangle skips the squares, root and divides).
// A result not yet taken holds the next one back.
// Synchronous active-low reset clears the sequencer, vertex count and output valid.
module triangle_tangent_generator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tt_vertex_if.sink    i_vtx,
    tt_tangent_if.source o_tan
);
    import tt_pkg::*;

    t_state r_state, n_state;
    logic [1:0] r_corner, n_corner;
    logic [3:0] r_cnt, n_cnt;

    logic [INDEX_WIDTH-1:0] r_idx [3];
    logic signed [COORD_W-1:0] r_pos [3][3];
    logic signed [COORD_W-1:0] r_tex [3][2];

    logic signed [DIFF_W-1:0] r_e1 [3];
    logic signed [DIFF_W-1:0] r_e2 [3];
    logic signed [DIFF_W-1:0] r_d1 [2];
    logic signed [DIFF_W-1:0] r_d2 [2];

    logic signed [PROD_W-1:0] r_acc;
    logic [SUM_W-1:0]         r_sum;
    logic [MAG_W-1:0]         r_mag [3];
    logic                     r_wneg [3];
    logic                     r_dneg, r_dzero, r_degen;
    logic [QUO_W-1:0]         r_quot [3];

    t_tangent r_out;
    logic     r_ovalid;

    logic signed [DIFF_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [WIDE_W-1:0] wdiff;
    logic [MAG_W-1:0]         wabs;
    logic [MAG_W-1:0]         mag_or;
    logic [SUM_W-1:0]         sum_next;
    logic                     root_start, root_done;
    logic [ROOT_W-1:0]        root;
    logic                     div_start, div_done;
    logic [NORM_BITS-1:0]     div_mag;
    logic [QUO_W-1:0]         quot;
    logic                     in_acc;
    t_tangent                 res;

    tt_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    tt_root u_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand ({sum_next, 12'b0}),
        .o_root     (root),
        .o_done     (root_done)
    );

    tt_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_mag     (div_mag),
        .i_divisor (root),
        .o_quot    (quot),
        .o_done    (div_done)
    );

    assign i_vtx.ready = (r_state == ST_IDLE);
    assign in_acc      = i_vtx.valid && i_vtx.ready;
    assign o_tan.valid = r_ovalid;
    assign o_tan.data  = r_out;

    assign wdiff    = {r_acc[PROD_W-1], r_acc} - {prod[PROD_W-1], prod};
    assign wabs     = wdiff[WIDE_W-1] ? MAG_W'(-wdiff) : MAG_W'(wdiff);
    assign mag_or   = r_mag[0] | r_mag[1] | r_mag[2];
    assign sum_next = r_sum + SUM_W'(prod);

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_PROD) begin
            case (r_cnt)
                4'd0: begin mul_a = r_d1[0]; mul_b = r_d2[1]; end
                4'd1: begin mul_a = r_d2[0]; mul_b = r_d1[1]; end
                4'd2: begin mul_a = r_d2[1]; mul_b = r_e1[0]; end
                4'd3: begin mul_a = r_d1[1]; mul_b = r_e2[0]; end
                4'd4: begin mul_a = r_d2[1]; mul_b = r_e1[1]; end
                4'd5: begin mul_a = r_d1[1]; mul_b = r_e2[1]; end
                4'd6: begin mul_a = r_d2[1]; mul_b = r_e1[2]; end
                4'd7: begin mul_a = r_d1[1]; mul_b = r_e2[2]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == ST_SQUARE) begin
            case (r_cnt)
                4'd0: mul_a = DIFF_W'(r_mag[0][NORM_BITS-1:0]);
                4'd1: mul_a = DIFF_W'(r_mag[1][NORM_BITS-1:0]);
                4'd2: mul_a = DIFF_W'(r_mag[2][NORM_BITS-1:0]);
                default: mul_a = '0;
            endcase
            mul_b = mul_a;
        end
    end

    // result assembly: saturate and apply sign
    always_comb begin
        logic [QUO_W-1:0] q;
        logic             neg;
        res.index_first  = IDX_W'(r_idx[0]);
        res.index_second = IDX_W'(r_idx[1]);
        res.index_third  = IDX_W'(r_idx[2]);
        res.degenerate   = r_degen;
        res.tangent_x    = '0;
        res.tangent_y    = '0;
        res.tangent_z    = '0;
        for (int k = 0; k < 3; k++) begin
            q   = (r_quot[k] > ONE_Q30) ? ONE_Q30 : r_quot[k];
            neg = (r_wneg[k] != r_dneg) && (q != '0);
            if (!r_degen) begin
                case (k)
                    0: res.tangent_x = neg ? OUT_W'(-q) : OUT_W'(q);
                    1: res.tangent_y = neg ? OUT_W'(-q) : OUT_W'(q);
                    default: res.tangent_z = neg ? OUT_W'(-q) : OUT_W'(q);
                endcase
            end
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_corner   = r_corner;
        n_cnt      = r_cnt;
        root_start = 1'b0;
        div_start  = 1'b0;
        div_mag    = r_mag[0][NORM_BITS-1:0];
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (r_corner == 2'd2) begin
                        n_corner = 2'd0;
                        n_state  = ST_DIFF;
                    end else begin
                        n_corner = r_corner + 2'd1;
                    end
                end
            end
            ST_DIFF: begin
                n_cnt   = '0;
                n_state = ST_PROD;
            end
            ST_PROD: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd8) begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                n_cnt = '0;
                if (r_dzero || mag_or == '0) begin
                    n_state = ST_OUT;
                end else if (mag_or[MAG_W-1:NORM_BITS] == '0 && mag_or[NORM_BITS-1]) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd3) begin
                    root_start = 1'b1;
                    n_state    = ST_ROOT;
                end
            end
            ST_ROOT: begin
                n_cnt = '0;
                if (root_done) begin
                    div_start = 1'b1;
                    div_mag   = r_mag[0][NORM_BITS-1:0];
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd2) begin
                        n_state = ST_OUT;
                    end else begin
                        div_start = 1'b1;
                        div_mag   = (r_cnt == 4'd0) ? r_mag[1][NORM_BITS-1:0]
                                                    : r_mag[2][NORM_BITS-1:0];
                    end
                end
            end
            ST_OUT: begin
                if (!r_ovalid || o_tan.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_corner <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_corner <= n_corner;
            r_cnt    <= n_cnt;
            if (r_state == ST_OUT && (!r_ovalid || o_tan.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_tan.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_idx[r_corner] <= i_vtx.data.vertex_index[INDEX_WIDTH-1:0];
            r_pos[r_corner][0] <= i_vtx.data.pos_x;
            r_pos[r_corner][1] <= i_vtx.data.pos_y;
            r_pos[r_corner][2] <= i_vtx.data.pos_z;
            r_tex[r_corner][0] <= i_vtx.data.tex_u;
            r_tex[r_corner][1] <= i_vtx.data.tex_v;
        end
        case (r_state)
            ST_DIFF: begin
                r_degen <= 1'b0;
                for (int k = 0; k < 3; k++) begin
                    r_e1[k] <= {r_pos[1][k][COORD_W-1], r_pos[1][k]}
                             - {r_pos[0][k][COORD_W-1], r_pos[0][k]};
                    r_e2[k] <= {r_pos[2][k][COORD_W-1], r_pos[2][k]}
                             - {r_pos[0][k][COORD_W-1], r_pos[0][k]};
                end
                for (int k = 0; k < 2; k++) begin
                    r_d1[k] <= {r_tex[1][k][COORD_W-1], r_tex[1][k]}
                             - {r_tex[0][k][COORD_W-1], r_tex[0][k]};
                    r_d2[k] <= {r_tex[2][k][COORD_W-1], r_tex[2][k]}
                             - {r_tex[0][k][COORD_W-1], r_tex[0][k]};
                end
            end
            ST_PROD: begin
                // consume the product issued last cycle
                if (r_cnt != 4'd0) begin
                    if (r_cnt[0]) begin
                        r_acc <= prod;
                    end else begin
                        case (r_cnt)
                            4'd2: begin
                                r_dneg  <= wdiff[WIDE_W-1];
                                r_dzero <= (wdiff == '0);
                            end
                            4'd4: begin r_mag[0] <= wabs; r_wneg[0] <= wdiff[WIDE_W-1]; end
                            4'd6: begin r_mag[1] <= wabs; r_wneg[1] <= wdiff[WIDE_W-1]; end
                            default: begin
                                r_mag[2]  <= wabs;
                                r_wneg[2] <= wdiff[WIDE_W-1];
                            end
                        endcase
                    end
                end
            end
            ST_NORM: begin
                r_sum <= '0;
                if (r_dzero || mag_or == '0) begin
                    r_degen <= 1'b1;
                end else if (mag_or[MAG_W-1:NORM_BITS] != '0) begin
                    // truncate one bit at a time until the top magnitude has 24 bits
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> 1;
                end else if (!mag_or[NORM_BITS-1]) begin
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 1;
                end
            end
            ST_SQUARE: begin
                if (r_cnt != 4'd0) begin
                    r_sum <= sum_next;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    case (r_cnt)
                        4'd0: r_quot[0] <= quot;
                        4'd1: r_quot[1] <= quot;
                        default: r_quot[2] <= quot;
                    endcase
                end
            end
            ST_OUT: begin
                if (!r_ovalid || o_tan.ready) begin
                    r_out <= res;
                end
            end
            default: ;
        endcase
    end
endmodule

// ----- src/tt_mul.sv -----
module tt_mul (
    input  logic                                 i_clk,
    input  logic signed [tt_pkg::DIFF_W-1:0]     i_a,
    input  logic signed [tt_pkg::DIFF_W-1:0]     i_b,
    output logic signed [tt_pkg::PROD_W-1:0]     o_prod
);
    import tt_pkg::*;

    always_ff @(posedge i_clk) begin
        o_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end
endmodule

// ----- src/tt_root.sv -----
module tt_root (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tt_pkg::RAD_W-1:0]    i_radicand,
    output logic [tt_pkg::ROOT_W-1:0]   o_root,
    output logic                        o_done
);
    import tt_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int TRY_W = REM_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  cand;

    assign trial = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign cand  = TRY_W'({o_root, 2'b01});

    // one result bit per cycle, two radicand bits brought down each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_radicand;
                r_rem  <= '0;
                o_root <= '0;
            end else if (r_busy) begin
                r_rad <= r_rad << 2;
                if (trial >= cand) begin
                    r_rem  <= REM_W'(trial - cand);
                    o_root <= {o_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= REM_W'(trial);
                    o_root <= {o_root[ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- src/tt_div.sv -----
module tt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tt_pkg::NORM_BITS-1:0]  i_mag,
    input  logic [tt_pkg::ROOT_W-1:0]     i_divisor,
    output logic [tt_pkg::QUO_W-1:0]      o_quot,
    output logic                          o_done
);
    import tt_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic [ROOT_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [ROOT_W:0]   shifted;

    assign shifted = {r_rem, 1'b0};

    // dividend is mag * 2^36; its top part mag * 2^4 is already below the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= ROOT_W'({i_mag, 4'b0});
                o_quot <= '0;
            end else if (r_busy) begin
                if (shifted >= {1'b0, i_divisor}) begin
                    r_rem  <= ROOT_W'(shifted - {1'b0, i_divisor});
                    o_quot <= {o_quot[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem  <= ROOT_W'(shifted);
                    o_quot <= {o_quot[QUO_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- tb/tt_checker.sv -----
`timescale 1ns / 1ps

module tt_checker
    import tt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    tt_vertex_if  i_vtx,
    tt_tangent_if i_tan,
    output int    o_fail_count,
    output int    o_pending
);

    typedef logic signed [127:0] t_big;

    t_tangent tangent_queue[$];
    t_vertex  corner_held[2];
    int       corners_seen;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bit_pos;
        root    = 0;
        bit_pos = 64'd1 << 62;
        while (bit_pos > x) bit_pos >>= 2;
        while (bit_pos != 0) begin
            if (x >= root + bit_pos) begin
                x    = x - (root + bit_pos);
                root = (root >> 1) + bit_pos;
            end else begin
                root >>= 1;
            end
            bit_pos >>= 2;
        end
        return root;
    endfunction

    function automatic t_tangent compute_tangent(t_vertex a, t_vertex b, t_vertex c);
        t_big            e1[3], e2[3], w[3], w_mag[3];
        t_big            d1u, d1v, d2u, d2v, det, scan;
        longint unsigned m[3], sum_sq, len, q;
        int              top, nbits;
        logic            neg;
        t_tangent        r;
        e1[0] = t_big'(b.pos_x) - t_big'(a.pos_x);
        e1[1] = t_big'(b.pos_y) - t_big'(a.pos_y);
        e1[2] = t_big'(b.pos_z) - t_big'(a.pos_z);
        e2[0] = t_big'(c.pos_x) - t_big'(a.pos_x);
        e2[1] = t_big'(c.pos_y) - t_big'(a.pos_y);
        e2[2] = t_big'(c.pos_z) - t_big'(a.pos_z);
        d1u   = t_big'(b.tex_u) - t_big'(a.tex_u);
        d1v   = t_big'(b.tex_v) - t_big'(a.tex_v);
        d2u   = t_big'(c.tex_u) - t_big'(a.tex_u);
        d2v   = t_big'(c.tex_v) - t_big'(a.tex_v);
        det   = d1u * d2v - d2u * d1v;
        top   = 0;
        for (int k = 0; k < 3; k++) begin
            w[k]     = d2v * e1[k] - d1v * e2[k];
            w_mag[k] = (w[k] < 0) ? -w[k] : w[k];
            nbits    = 0;
            scan     = w_mag[k];
            while (scan != 0) begin
                nbits++;
                scan = scan >>> 1;
            end
            if (nbits > top) top = nbits;
        end
        r.index_first  = a.vertex_index;
        r.index_second = b.vertex_index;
        r.index_third  = c.vertex_index;
        r.degenerate   = (det == 0) || (top == 0);
        r.tangent_x    = '0;
        r.tangent_y    = '0;
        r.tangent_z    = '0;
        if (r.degenerate) return r;
        sum_sq = 0;
        for (int k = 0; k < 3; k++) begin
            // bring the largest magnitude to exactly NORM_BITS bits
            if (top > NORM_BITS) m[k] = 64'(w_mag[k] >> (top - NORM_BITS));
            else                 m[k] = 64'(w_mag[k] << (NORM_BITS - top));
            sum_sq += m[k] * m[k];
        end
        len = int_sqrt(sum_sq << 12);
        for (int k = 0; k < 3; k++) begin
            q = (m[k] << 36) / len;
            if (q > 64'(ONE_Q30)) q = 64'(ONE_Q30);
            neg = ((w[k] < 0) != (det < 0)) && (q != 0);
            if (k == 0) r.tangent_x = neg ? -q[31:0] : q[31:0];
            if (k == 1) r.tangent_y = neg ? -q[31:0] : q[31:0];
            if (k == 2) r.tangent_z = neg ? -q[31:0] : q[31:0];
        end
        return r;
    endfunction

    task automatic check_field(string name, longint expected, longint actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tangent want;
        t_tangent got;
        if (!i_rst_n) begin
            corners_seen = 0;
            tangent_queue.delete();
        end else begin
            if (i_tan.valid && i_tan.ready) begin
                got = i_tan.data;
                if (tangent_queue.size() == 0) begin
                    $error("tangent item with nothing expected");
                    o_fail_count++;
                end else begin
                    want = tangent_queue.pop_front();
                    check_field("index_first", want.index_first, got.index_first);
                    check_field("index_second", want.index_second, got.index_second);
                    check_field("index_third", want.index_third, got.index_third);
                    check_field("tangent_x", want.tangent_x, got.tangent_x);
                    check_field("tangent_y", want.tangent_y, got.tangent_y);
                    check_field("tangent_z", want.tangent_z, got.tangent_z);
                    check_field("degenerate", want.degenerate, got.degenerate);
                end
            end
            if (i_vtx.valid && i_vtx.ready) begin
                if (corners_seen < 2) begin
                    corner_held[corners_seen] = i_vtx.data;
                    corners_seen++;
                end else begin
                    tangent_queue = {tangent_queue,
                        compute_tangent(corner_held[0], corner_held[1], i_vtx.data)};
                    corners_seen = 0;
                end
            end
        end
        o_pending = tangent_queue.size();
    end

endmodule

// ----- tb/triangle_tangent_generator_test.sv -----
`timescale 1ns / 1ps

module triangle_tangent_generator_test;
    import tt_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_TRIANGLES = 150;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   hold_left = 0;

    tt_vertex_if  vtx_ch();
    tt_tangent_if tan_ch();

    triangle_tangent_generator i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vtx  (vtx_ch.sink),
        .o_tan  (tan_ch.source)
    );

    tt_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vtx       (vtx_ch),
        .i_tan       (tan_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: mostly random stalls, some stretches always ready, one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tan_ch.ready <= 1'b0;
        end else if (cycle_count == 4000) begin
            hold_left = 1500;
            tan_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            tan_ch.ready <= 1'b0;
        end else if ((cycle_count / 512) % 3 == 0) begin
            tan_ch.ready <= 1'b1;
        end else begin
            tan_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    int burst_left = 0;

    task automatic send_vertex(t_vertex v);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                vtx_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        vtx_ch.valid <= 1'b1;
        vtx_ch.data  <= v;
        @(posedge i_clk);
        while (!vtx_ch.ready) @(posedge i_clk);
    endtask

    task automatic drop_valid();
        vtx_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 131071)) - 65536);
            2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 255)) - 128) << 16;
        endcase
    endfunction

    function automatic t_vertex make_vertex(int mode);
        t_vertex v;
        v.vertex_index = 16'($urandom_range(0, 65535));
        v.pos_x = pick_coord(mode);
        v.pos_y = pick_coord(mode);
        v.pos_z = pick_coord(mode);
        v.tex_u = pick_coord(mode);
        v.tex_v = pick_coord(mode);
        return v;
    endfunction

    function automatic t_vertex fixed_vertex(logic [15:0] idx, int px, int py, int pz,
                                             int tu, int tv);
        t_vertex v;
        v.vertex_index = idx;
        v.pos_x = px;
        v.pos_y = py;
        v.pos_z = pz;
        v.tex_u = tu;
        v.tex_v = tv;
        return v;
    endfunction

    task automatic send_triangle(t_vertex a, t_vertex b, t_vertex c);
        send_vertex(a);
        send_vertex(b);
        send_vertex(c);
    endtask

    initial begin
        t_vertex a, b, c;
        int      mode;
        int      flavor;
        vtx_ch.valid = 1'b0;
        vtx_ch.data  = '0;
        i_rst_n      = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain triangle, unit UV square
        send_triangle(fixed_vertex(16'd0, 0, 0, 0, 0, 0),
                      fixed_vertex(16'd1, 32'h10000, 0, 0, 32'h10000, 0),
                      fixed_vertex(16'hFFFF, 0, 32'h10000, 0, 0, 32'h10000));
        // mirrored UV: negative determinant
        send_triangle(fixed_vertex(16'd5, 0, 0, 0, 0, 0),
                      fixed_vertex(16'd6, 32'h10000, 0, 32'h20000, 0, 32'h10000),
                      fixed_vertex(16'd7, 0, 32'h10000, 0, 32'h10000, 0));
        // degenerate: identical texture coordinates
        send_triangle(fixed_vertex(16'd10, 0, 0, 0, 32'h5000, 32'h5000),
                      fixed_vertex(16'd11, 32'h10000, 0, 0, 32'h5000, 32'h5000),
                      fixed_vertex(16'd12, 0, 32'h10000, 0, 32'h5000, 32'h5000));
        // degenerate: all positions equal, UV fine
        send_triangle(fixed_vertex(16'd20, 7, 7, 7, 0, 0),
                      fixed_vertex(16'd21, 7, 7, 7, 32'h10000, 0),
                      fixed_vertex(16'd22, 7, 7, 7, 0, 32'h10000));
        // extremes of every coordinate field
        send_triangle(fixed_vertex(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h8000_0000, 32'h8000_0000),
                      fixed_vertex(16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h8000_0000),
                      fixed_vertex(16'h8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h7FFF_FFFF));
        send_triangle(fixed_vertex(16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF),
                      fixed_vertex(16'h1234, 32'h8000_0000, 0, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h7FFF_FFFF),
                      fixed_vertex(16'hABCD, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h8000_0000));
        // tiny deltas: left-shift normalization
        send_triangle(fixed_vertex(16'd30, 0, 0, 0, 0, 0),
                      fixed_vertex(16'd31, 1, 0, 0, 1, 0),
                      fixed_vertex(16'd32, 0, 1, 1, 0, 1));
        drop_valid();
        wait (pending == 0);
        @(posedge i_clk);

        for (int t = 0; t < RANDOM_TRIANGLES; t++) begin
            if (t == RANDOM_TRIANGLES / 2) begin
                // hold off until every result has come back
                drop_valid();
                wait (pending == 0);
                @(posedge i_clk);
            end
            mode   = $urandom_range(0, 3);
            flavor = $urandom_range(0, 9);
            a = make_vertex(mode);
            b = make_vertex(mode);
            c = make_vertex(mode);
            if (flavor == 0) begin
                b.tex_u = a.tex_u;
                b.tex_v = a.tex_v;
                c.tex_u = a.tex_u;
                c.tex_v = a.tex_v;
            end else if (flavor == 1) begin
                // UV collinear: det zero but deltas nonzero, where 2*b - a fits in 32 bits
                c.tex_u = 32'(2 * $signed(b.tex_u) - $signed(a.tex_u));
                c.tex_v = 32'(2 * $signed(b.tex_v) - $signed(a.tex_v));
            end else if (flavor == 2) begin
                b.pos_x = a.pos_x; b.pos_y = a.pos_y; b.pos_z = a.pos_z;
                c.pos_x = a.pos_x; c.pos_y = a.pos_y; c.pos_z = a.pos_z;
            end
            send_triangle(a, b, c);
        end
        drop_valid();

        wait (pending == 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
